/* src/pov_scan_pkg.sv */
package pov_scan_pkg;

    localparam int GLYPH_WIDTH  = 5;
    localparam int TEXT_LEN     = 16;
    localparam int DIGIT_COUNT  = 10;
    localparam int LETTER_COUNT = 26;
    localparam int GLYPH_COUNT  = DIGIT_COUNT + LETTER_COUNT + 2;

    localparam logic [63:0] SPACE_TEXT   = 64'h2020_2020_2020_2020;
    localparam logic [3:0]  LIMIT_RESET  = 4'd5;
    localparam logic [3:0]  SETTLE_RESET = 4'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TEXT_FIRST  = 2'd0;
    localparam logic [1:0] CFG_TEXT_SECOND = 2'd1;
    localparam logic [1:0] CFG_LIMIT       = 2'd2;
    localparam logic [1:0] CFG_SETTLE      = 2'd3;

    // request action codes
    localparam logic ACT_DISPLAY = 1'b0;
    localparam logic ACT_SAMPLE  = 1'b1;

    typedef struct packed {
        logic action;
        logic sensor_level;
    } req_t;

    typedef struct packed {
        logic [7:0] led_column;
        logic       sweep_started;
        logic       sweep_busy;
    } rsp_t;

    // 5x8 font: digits, letters, space, unknown-glyph box
    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_WIDTH] = '{
        '{8'h7E, 8'hA1, 8'h99, 8'h85, 8'h7E}, '{8'h00, 8'h82, 8'hFF, 8'h80, 8'h00},
        '{8'h82, 8'hC1, 8'hA1, 8'h91, 8'h8E}, '{8'h42, 8'h81, 8'h89, 8'h89, 8'h76},
        '{8'h18, 8'h14, 8'h12, 8'hFF, 8'h10}, '{8'h4F, 8'h89, 8'h89, 8'h89, 8'h71},
        '{8'h7E, 8'h89, 8'h89, 8'h89, 8'h72}, '{8'h01, 8'hC1, 8'h31, 8'h0D, 8'h03},
        '{8'h76, 8'h89, 8'h89, 8'h89, 8'h76}, '{8'h46, 8'h89, 8'h89, 8'h89, 8'h7E},
        '{8'hFE, 8'h09, 8'h09, 8'h09, 8'hFE}, '{8'hFF, 8'h89, 8'h89, 8'h89, 8'h76},
        '{8'h7E, 8'h81, 8'h81, 8'h81, 8'h42}, '{8'hFF, 8'h81, 8'h81, 8'h81, 8'h7E},
        '{8'hFF, 8'h89, 8'h89, 8'h89, 8'h81}, '{8'hFF, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h7E, 8'h81, 8'h81, 8'h91, 8'hF2}, '{8'hFF, 8'h08, 8'h08, 8'h08, 8'hFF},
        '{8'h00, 8'h81, 8'hFF, 8'h81, 8'h00}, '{8'h60, 8'h80, 8'h81, 8'h7F, 8'h00},
        '{8'hFF, 8'h08, 8'h14, 8'h22, 8'hC1}, '{8'hFF, 8'h80, 8'h80, 8'h80, 8'h80},
        '{8'hFF, 8'h06, 8'h38, 8'h06, 8'hFF}, '{8'hFF, 8'h06, 8'h18, 8'h60, 8'hFF},
        '{8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E}, '{8'hFF, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h7E, 8'h81, 8'hA1, 8'h41, 8'hBE}, '{8'hFF, 8'h09, 8'h09, 8'h19, 8'hE6},
        '{8'h46, 8'h89, 8'h89, 8'h89, 8'h72}, '{8'h01, 8'h01, 8'hFF, 8'h01, 8'h01},
        '{8'h7F, 8'h80, 8'h80, 8'h80, 8'h7F}, '{8'h1F, 8'h60, 8'h80, 8'h60, 8'h1F},
        '{8'hFF, 8'h60, 8'h1C, 8'h60, 8'hFF}, '{8'hC3, 8'h34, 8'h08, 8'h34, 8'hC3},
        '{8'h03, 8'h0C, 8'hF0, 8'h0C, 8'h03}, '{8'hC1, 8'hA1, 8'h99, 8'h85, 8'h83},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'hFF, 8'h81, 8'h81, 8'h81, 8'hFF}
    };

    // ASCII code to font row
    function automatic logic [5:0] glyph_index(input logic [7:0] c);
        logic [7:0] idx;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            idx = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            idx = 8'(DIGIT_COUNT) + (c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            idx = 8'(DIGIT_COUNT) + (c - 8'h61);
        end
        else if (c == 8'h20)
        begin
            idx = 8'(DIGIT_COUNT + LETTER_COUNT);
        end
        else
        begin
            idx = 8'(DIGIT_COUNT + LETTER_COUNT + 1);
        end
        return idx[5:0];
    endfunction

endpackage

/* src/pov_text_column_scanner.sv */
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  req_t: action, sensor_level
// response  out        rsp_valid/rsp_stall  rsp_t: led_column, sweep_started, sweep_busy
// config    in         cfg_write_enable     cfg_index, cfg_data (64 bits)
//
// One request every cycle unless req_stall holds it, one response per request.
// The state update and the font lookup sit between the state registers and
// the response register; the response register plus one skid entry decouple
// the two sides, so req_stall rises only when both are full.
// rst_n clears state asynchronously: sweep idle, debouncer waiting for press,
// text all spaces, debounce limit 5, settle 3.
module pov_text_column_scanner
    import pov_scan_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [1:0] {
        PH_PRESS   = 2'd0,
        PH_RELEASE = 2'd1,
        PH_SETTLE  = 2'd2
    } phase_t;

    // configuration
    logic [63:0] text_first_half_reg;
    logic [63:0] text_second_half_reg;
    logic [3:0]  debounce_limit_reg;
    logic [3:0]  settle_ticks_reg;

    // sweep position kept as character / column so no divide by six is needed
    logic        sweep_busy_reg,  sweep_busy_next;
    logic [3:0]  sweep_char_reg,  sweep_char_next;
    logic [2:0]  sweep_col_reg,   sweep_col_next;
    phase_t      phase_reg,       phase_next;
    logic [3:0]  count_reg,       count_next;
    logic [7:0]  led_drive_reg,   led_drive_next;

    // output register and skid entry
    logic        rsp_valid_reg,   rsp_valid_next;
    rsp_t        rsp_reg,         rsp_next;
    logic        skid_valid_reg,  skid_valid_next;
    rsp_t        skid_reg,        skid_next;

    logic        accept;
    logic        started;
    rsp_t        result;
    logic [63:0] text_half;
    logic [7:0]  text_byte;
    logic [5:0]  glyph;
    logic        toward;
    logic [3:0]  step_count;
    logic [3:0]  settle_count;

    assign accept    = req_valid && !req_stall;
    assign req_stall = skid_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // current character of the text and its font row
    always_comb
    begin
        text_half = sweep_char_reg[3] ? text_second_half_reg : text_first_half_reg;
        text_byte = text_half[{sweep_char_reg[2:0], 3'b000} +: 8];
        glyph     = glyph_index(text_byte);
    end

    // debouncer saturating counter step; press phase counts up when released
    always_comb
    begin
        toward     = (phase_reg == PH_RELEASE) ? !req.sensor_level : req.sensor_level;
        step_count = count_reg;
        if (toward)
        begin
            if (count_reg < debounce_limit_reg)
            begin
                step_count = count_reg + 4'd1;
            end
        end
        else if (count_reg != 4'd0)
        begin
            step_count = count_reg - 4'd1;
        end
        settle_count = count_reg + 4'd1;
    end

    always_comb
    begin
        sweep_busy_next = sweep_busy_reg;
        sweep_char_next = sweep_char_reg;
        sweep_col_next  = sweep_col_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        led_drive_next  = led_drive_reg;
        started         = 1'b0;

        if (req.action == ACT_DISPLAY)
        begin
            if (sweep_busy_reg)
            begin
                // gap column after each glyph
                if (sweep_col_reg < 3'(GLYPH_WIDTH))
                begin
                    led_drive_next = GLYPH_ROM[glyph][sweep_col_reg];
                end
                else
                begin
                    led_drive_next = 8'h00;
                end
                if (sweep_col_reg == 3'(GLYPH_WIDTH))
                begin
                    sweep_col_next  = 3'd0;
                    sweep_char_next = sweep_char_reg + 4'd1;
                    if (sweep_char_reg == 4'(TEXT_LEN - 1))
                    begin
                        sweep_busy_next = 1'b0;
                    end
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 3'd1;
                end
            end
            else
            begin
                led_drive_next = 8'h00;
            end
        end
        else
        begin
            case (phase_reg)
                PH_RELEASE:
                begin
                    count_next = step_count;
                    if (step_count == 4'd0)
                    begin
                        phase_next = PH_SETTLE;
                        count_next = 4'd0;
                        if (settle_ticks_reg == 4'd0)
                        begin
                            started = 1'b1;
                        end
                    end
                end
                PH_SETTLE:
                begin
                    count_next = settle_count;
                    if (settle_count >= settle_ticks_reg)
                    begin
                        started = 1'b1;
                    end
                end
                default:
                begin
                    count_next = step_count;
                    if (step_count == 4'd0)
                    begin
                        phase_next = PH_RELEASE;
                        count_next = debounce_limit_reg;
                    end
                end
            endcase
            // a restart during a sweep rewinds it
            if (started)
            begin
                sweep_busy_next = 1'b1;
                sweep_char_next = 4'd0;
                sweep_col_next  = 3'd0;
                phase_next      = PH_PRESS;
                count_next      = debounce_limit_reg;
            end
        end

        result.led_column    = led_drive_next;
        result.sweep_started = started;
        result.sweep_busy    = sweep_busy_next;
    end

    // response register with one skid entry behind it
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!rsp_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
            begin
                rsp_valid_next  = 1'b1;
                rsp_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                rsp_valid_next = accept;
                if (accept)
                begin
                    rsp_next = result;
                end
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_first_half_reg  <= SPACE_TEXT;
            text_second_half_reg <= SPACE_TEXT;
            debounce_limit_reg   <= LIMIT_RESET;
            settle_ticks_reg     <= SETTLE_RESET;
            sweep_busy_reg       <= 1'b0;
            sweep_char_reg       <= 4'd0;
            sweep_col_reg        <= 3'd0;
            phase_reg            <= PH_PRESS;
            count_reg            <= LIMIT_RESET;
            led_drive_reg        <= 8'h00;
            rsp_valid_reg        <= 1'b0;
            rsp_reg              <= '0;
            skid_valid_reg       <= 1'b0;
            skid_reg             <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_TEXT_FIRST:  text_first_half_reg  <= cfg_data;
                    CFG_TEXT_SECOND: text_second_half_reg <= cfg_data;
                    CFG_LIMIT:       debounce_limit_reg   <= cfg_data[3:0];
                    CFG_SETTLE:      settle_ticks_reg     <= cfg_data[3:0];
                    default:         settle_ticks_reg     <= settle_ticks_reg;
                endcase
            end
            if (accept)
            begin
                sweep_busy_reg <= sweep_busy_next;
                sweep_char_reg <= sweep_char_next;
                sweep_col_reg  <= sweep_col_next;
                phase_reg      <= phase_next;
                count_reg      <= count_next;
                led_drive_reg  <= led_drive_next;
            end
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
            skid_valid_reg <= skid_valid_next;
            skid_reg       <= skid_next;
        end
    end

    // skid entry only fills behind a held response
    a_skid_behind_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid entry valid with empty response register");

    // a restart always leaves the sweep running
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_reg.sweep_started || rsp_reg.sweep_busy))
        else $error("sweep restart reported without busy");

    // idle display tick blanks the port
    a_idle_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_DISPLAY && !sweep_busy_reg) |=> led_drive_reg == 8'h00)
        else $error("idle display tick left LEDs driven");

    // gap column after a glyph is blank
    a_gap_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_DISPLAY && sweep_busy_reg
         && sweep_col_reg == 3'(GLYPH_WIDTH)) |=> led_drive_reg == 8'h00)
        else $error("gap column not blank");

    // last column of the last character ends the sweep
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_DISPLAY && sweep_busy_reg
         && sweep_col_reg == 3'(GLYPH_WIDTH)
         && sweep_char_reg == 4'(TEXT_LEN - 1)) |=> !sweep_busy_reg)
        else $error("sweep did not end after last column");

endmodule

/* sim/pov_scan_checker.sv */
module pov_scan_checker
    import pov_scan_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);

    localparam int         CELL_WIDTH  = GLYPH_WIDTH + 1;
    localparam logic [6:0] SWEEP_LIMIT = 7'(TEXT_LEN * CELL_WIDTH);

    typedef enum logic [1:0] {WAIT_PRESS, WAIT_RELEASE, SETTLING, SPARE_PHASE} dbnc_state_t;

    // digits, letters, space, unknown box
    localparam logic [7:0] FONT [38][5] = '{
        '{8'h7E, 8'hA1, 8'h99, 8'h85, 8'h7E}, '{8'h00, 8'h82, 8'hFF, 8'h80, 8'h00},
        '{8'h82, 8'hC1, 8'hA1, 8'h91, 8'h8E}, '{8'h42, 8'h81, 8'h89, 8'h89, 8'h76},
        '{8'h18, 8'h14, 8'h12, 8'hFF, 8'h10}, '{8'h4F, 8'h89, 8'h89, 8'h89, 8'h71},
        '{8'h7E, 8'h89, 8'h89, 8'h89, 8'h72}, '{8'h01, 8'hC1, 8'h31, 8'h0D, 8'h03},
        '{8'h76, 8'h89, 8'h89, 8'h89, 8'h76}, '{8'h46, 8'h89, 8'h89, 8'h89, 8'h7E},
        '{8'hFE, 8'h09, 8'h09, 8'h09, 8'hFE}, '{8'hFF, 8'h89, 8'h89, 8'h89, 8'h76},
        '{8'h7E, 8'h81, 8'h81, 8'h81, 8'h42}, '{8'hFF, 8'h81, 8'h81, 8'h81, 8'h7E},
        '{8'hFF, 8'h89, 8'h89, 8'h89, 8'h81}, '{8'hFF, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h7E, 8'h81, 8'h81, 8'h91, 8'hF2}, '{8'hFF, 8'h08, 8'h08, 8'h08, 8'hFF},
        '{8'h00, 8'h81, 8'hFF, 8'h81, 8'h00}, '{8'h60, 8'h80, 8'h81, 8'h7F, 8'h00},
        '{8'hFF, 8'h08, 8'h14, 8'h22, 8'hC1}, '{8'hFF, 8'h80, 8'h80, 8'h80, 8'h80},
        '{8'hFF, 8'h06, 8'h38, 8'h06, 8'hFF}, '{8'hFF, 8'h06, 8'h18, 8'h60, 8'hFF},
        '{8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E}, '{8'hFF, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h7E, 8'h81, 8'hA1, 8'h41, 8'hBE}, '{8'hFF, 8'h09, 8'h09, 8'h19, 8'hE6},
        '{8'h46, 8'h89, 8'h89, 8'h89, 8'h72}, '{8'h01, 8'h01, 8'hFF, 8'h01, 8'h01},
        '{8'h7F, 8'h80, 8'h80, 8'h80, 8'h7F}, '{8'h1F, 8'h60, 8'h80, 8'h60, 8'h1F},
        '{8'hFF, 8'h60, 8'h1C, 8'h60, 8'hFF}, '{8'hC3, 8'h34, 8'h08, 8'h34, 8'hC3},
        '{8'h03, 8'h0C, 8'hF0, 8'h0C, 8'h03}, '{8'hC1, 8'hA1, 8'h99, 8'h85, 8'h83},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'hFF, 8'h81, 8'h81, 8'h81, 8'hFF}
    };

    logic [63:0] msg_lo     = SPACE_TEXT;
    logic [63:0] msg_hi     = SPACE_TEXT;
    logic [3:0]  cfg_limit  = LIMIT_RESET;
    logic [3:0]  cfg_settle = SETTLE_RESET;
    logic [6:0]  col_ptr    = SWEEP_LIMIT;
    dbnc_state_t dbnc_state = WAIT_PRESS;
    logic [3:0]  dbnc_cnt   = LIMIT_RESET;
    logic [7:0]  port_val   = 8'h00;

    rsp_t expected_columns [$];
    rsp_t want;

    function automatic int font_row(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return c - 8'h30;
        end
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return 10 + (c - 8'h41);
        end
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return 10 + (c - 8'h61);
        end
        if (c == 8'h20)
        begin
            return 36;
        end
        return 37;
    endfunction

    // saturating count toward the limit or toward zero; 1 when it sits at zero
    function automatic logic dbnc_bump(input logic up);
        if (up)
        begin
            if (dbnc_cnt < cfg_limit)
            begin
                dbnc_cnt = dbnc_cnt + 4'd1;
            end
        end
        else if (dbnc_cnt > 4'd0)
        begin
            dbnc_cnt = dbnc_cnt - 4'd1;
        end
        return dbnc_cnt == 4'd0;
    endfunction

    function automatic rsp_t scan_and_debounce(input req_t r);
        rsp_t        res;
        logic        restart;
        logic [127:0] msg;
        int          col;
        int          chr;
        restart = 1'b0;
        msg = {msg_hi, msg_lo};
        if (r.action == ACT_DISPLAY)
        begin
            if (col_ptr < SWEEP_LIMIT)
            begin
                col = col_ptr % CELL_WIDTH;
                chr = col_ptr / CELL_WIDTH;
                port_val = (col < GLYPH_WIDTH) ? FONT[font_row(msg[chr*8 +: 8])][col] : 8'h00;
                col_ptr = col_ptr + 7'd1;
            end
            else
            begin
                port_val = 8'h00;
            end
        end
        else
        begin
            case (dbnc_state)
                WAIT_RELEASE:
                begin
                    if (dbnc_bump(!r.sensor_level))
                    begin
                        dbnc_state = SETTLING;
                        dbnc_cnt = 4'd0;
                        restart = (cfg_settle == 4'd0);
                    end
                end
                SETTLING:
                begin
                    dbnc_cnt = dbnc_cnt + 4'd1;
                    restart = (dbnc_cnt >= cfg_settle);
                end
                default:
                begin
                    if (dbnc_bump(r.sensor_level))
                    begin
                        dbnc_state = WAIT_RELEASE;
                        dbnc_cnt = cfg_limit;
                    end
                end
            endcase
            if (restart)
            begin
                col_ptr = 7'd0;
                dbnc_state = WAIT_PRESS;
                dbnc_cnt = cfg_limit;
            end
        end
        res.led_column    = port_val;
        res.sweep_started = restart;
        res.sweep_busy    = (col_ptr < SWEEP_LIMIT);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_lo     = SPACE_TEXT;
            msg_hi     = SPACE_TEXT;
            cfg_limit  = LIMIT_RESET;
            cfg_settle = SETTLE_RESET;
            col_ptr    = SWEEP_LIMIT;
            dbnc_state = WAIT_PRESS;
            dbnc_cnt   = LIMIT_RESET;
            port_val   = 8'h00;
            fail_count = 0;
            expected_columns.delete();
        end
        else
        begin
            // response side first: it can only belong to an older request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_columns.size() == 0)
                begin
                    $error("response with nothing expected: %p", rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_columns.pop_front();
                    if (rsp.led_column !== want.led_column)
                    begin
                        $error("led_column: expected %h, got %h", want.led_column,
                               rsp.led_column);
                        fail_count++;
                    end
                    if (rsp.sweep_started !== want.sweep_started)
                    begin
                        $error("sweep_started: expected %b, got %b", want.sweep_started,
                               rsp.sweep_started);
                        fail_count++;
                    end
                    if (rsp.sweep_busy !== want.sweep_busy)
                    begin
                        $error("sweep_busy: expected %b, got %b", want.sweep_busy,
                               rsp.sweep_busy);
                        fail_count++;
                    end
                end
            end
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_TEXT_FIRST:  msg_lo = cfg_data;
                    CFG_TEXT_SECOND: msg_hi = cfg_data;
                    CFG_LIMIT:       cfg_limit = cfg_data[3:0];
                    CFG_SETTLE:      cfg_settle = cfg_data[3:0];
                    default:         ;
                endcase
            end
            if (req_valid && !req_stall)
            begin
                expected_columns.push_back(scan_and_debounce(req));
            end
        end
        outstanding = expected_columns.size();
    end

endmodule

/* sim/tb_pov_text_column_scanner.sv */
module tb_pov_text_column_scanner;
    import pov_scan_pkg::*;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        req_valid        = 1'b0;
    logic        req_stall;
    req_t        req              = '0;
    logic        rsp_valid;
    logic        rsp_stall        = 1'b0;
    rsp_t        rsp;
    logic        cfg_write_enable = 1'b0;
    logic [1:0]  cfg_index        = CFG_TEXT_FIRST;
    logic [63:0] cfg_data         = '0;

    int          fail_count;
    int          outstanding;

    // percent of cycles in which the sender idles and the receiver stalls
    int          idle_pct   = 38;
    int          sent       = 0;
    // what the debouncer was last programmed with, to size the gestures
    int          limit_now  = LIMIT_RESET;
    int          settle_now = SETTLE_RESET;

    always #1 clk = ~clk;

    pov_text_column_scanner u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .rsp              (rsp),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    pov_scan_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .rsp              (rsp),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // receiver backpressure, redrawn every falling edge
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < idle_pct);
    end

    // Present one request and hold it until the block takes it. Random idle
    // cycles go in front; valid stays high from one request to the next when
    // no idle cycle is drawn.
    task automatic push_request(input logic act, input logic level);
        req_t item;
        item.action       = act;
        item.sensor_level = level;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic drain_requests();
        req_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(negedge clk);
    endtask

    // All four registers, back to back; the short ones get junk in the
    // upper bits, which the block must ignore.
    task automatic program_regs(input logic [63:0] first, input logic [63:0] second,
                                input logic [3:0] lim, input logic [3:0] settle);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_TEXT_FIRST, first);
        write_reg(CFG_TEXT_SECOND, second);
        write_reg(CFG_LIMIT, {junk[63:4], lim});
        write_reg(CFG_SETTLE, {~junk[63:4], settle});
        cfg_write_enable <= 1'b0;
        limit_now  = lim;
        settle_now = settle;
    endtask

    // mostly printable glyphs, the rest any byte (unknown box)
    function automatic logic [63:0] random_text();
        logic [63:0] t;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(4))
                0:       t[i*8 +: 8] = 8'(8'h30 + $urandom_range(9));
                1:       t[i*8 +: 8] = 8'(8'h41 + $urandom_range(25));
                2:       t[i*8 +: 8] = 8'(8'h61 + $urandom_range(25));
                3:       t[i*8 +: 8] = 8'h20;
                default: t[i*8 +: 8] = 8'($urandom);
            endcase
        end
        return t;
    endfunction

    // A run of samples at one level, with contact bounce and display ticks
    // sprinkled in.
    task automatic hold_sensor(input logic level, input int samples);
        repeat (samples)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_request(ACT_SAMPLE, ~level);
            end
            if ($urandom_range(99) < 25)
            begin
                push_request(ACT_DISPLAY, 1'($urandom));
            end
            push_request(ACT_SAMPLE, level);
        end
    endtask

    // Press, release, settle, then a stretch of display ticks that usually
    // runs through much of the sweep.
    task automatic press_gesture();
        hold_sensor(1'b0, limit_now + $urandom_range(2));
        hold_sensor(1'b1, limit_now + $urandom_range(2));
        repeat (settle_now + $urandom_range(1))
        begin
            push_request(ACT_SAMPLE, 1'($urandom));
        end
        repeat ($urandom_range(8, 60))
        begin
            push_request(ACT_DISPLAY, 1'($urandom));
        end
    endtask

    // Gestures mixed with bursts of noise; the phase may end anywhere inside
    // a debounce phase, so the next register write lands mid-phase.
    task automatic random_phase(input int amount);
        int goal;
        goal = sent + amount;
        while (sent < goal)
        begin
            if ($urandom_range(99) < 75)
            begin
                press_gesture();
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    push_request(1'($urandom), 1'($urandom));
                end
            end
        end
        drain_requests();
    endtask

    initial
    begin
        repeat (9)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: all-space text, limit 5, settle 3
        random_phase(20);

        // Text hits every range edge: "09AZaz ~" then the bytes just
        // outside each range, NUL and 0xFF. Limit 1 with zero settle.
        program_regs(64'h7E20_7A61_5A41_3930, 64'hFF00_7B60_5B40_3A2F, 4'd1, 4'd0);
        push_request(ACT_DISPLAY, 1'b0);   // idle display tick drives 0
        push_request(ACT_SAMPLE, 1'b1);    // released while at the ceiling
        push_request(ACT_SAMPLE, 1'b0);    // press completes
        push_request(ACT_SAMPLE, 1'b0);    // still pressed, held at the ceiling
        push_request(ACT_SAMPLE, 1'b1);    // release completes, zero settle starts
        repeat (13)
        begin
            push_request(ACT_DISPLAY, 1'b1);
        end
        push_request(ACT_SAMPLE, 1'b0);    // sample tick repeats the port value
        push_request(ACT_SAMPLE, 1'b1);    // restart in the middle of a sweep
        push_request(ACT_DISPLAY, 1'b0);
        random_phase(25);

        // ceilings at their widest
        program_regs(random_text(), random_text(), 4'd15, 4'd15);
        random_phase(20);

        // zero limit, zero settle, text of all NUL and all 0xFF
        program_regs(64'h0, {64{1'b1}}, 4'd0, 4'd0);
        random_phase(20);

        // a long stretch with no idling on either side
        idle_pct = 0;
        program_regs(random_text(), random_text(), 4'd3, 4'd1);
        random_phase(40);
        idle_pct = 38;

        // limit lowered under a possibly high count, settle raised
        program_regs(random_text(), random_text(), 4'd1, 4'd15);
        random_phase(20);

        program_regs(random_text(), random_text(), 4'($urandom), 4'($urandom));
        random_phase(20);

        program_regs(random_text(), random_text(), 4'd2, 4'd4);
        random_phase(20);

        // spare cycles at the end catch stray responses
        repeat (4)
        begin
            @(negedge clk);
        end
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #500000;
        $display("FAIL");
        $finish;
    end

endmodule
